// ----- hdl/srms_pkg.sv -----
// shared types, constants and a helper function of the sampled region mean and sd block
package srms_pkg;

  // sizes of the statistics and counters
  localparam int unsigned MAX_REGION_PIXELS = 16777216;
  localparam int unsigned MAX_IMAGE_WIDTH   = 65536;
  localparam int unsigned CNT_W    = 25;
  localparam int unsigned POS_W    = 16;
  localparam int unsigned SUM_W    = 41;
  localparam int unsigned SQSUM_W  = 56;
  localparam int unsigned VAL_W    = 17;
  localparam int unsigned NPIX_W   = 34;
  localparam int unsigned PROD_W   = 81;
  localparam int unsigned MPLR_W   = 40;
  localparam int unsigned DVD_W    = 97;
  localparam int unsigned DVS_W    = 62;
  localparam int unsigned QUO_W    = 64;
  localparam int unsigned SQRT_W   = 64;

  // luminance weights and scales
  localparam logic [VAL_W-1:0] WEIGHT_RED   = 17'd30;
  localparam logic [VAL_W-1:0] WEIGHT_GREEN = 17'd59;
  localparam logic [VAL_W-1:0] WEIGHT_BLUE  = 17'd11;
  localparam logic [6:0]  RGB_SCALE    = 7'd100;
  localparam logic [13:0] RGB_SCALE_SQ = 14'd10000;
  localparam logic [NPIX_W-1:0] MIN_SAMPLES = 34'd5;
  localparam logic [CNT_W-1:0]  STRIDE_ADJUST_ABOVE = 25'd5;

  // pixel formats
  localparam logic [2:0] FMT_U8   = 3'd0;
  localparam logic [2:0] FMT_S8   = 3'd1;
  localparam logic [2:0] FMT_U16  = 3'd2;
  localparam logic [2:0] FMT_S16  = 3'd3;
  localparam logic [2:0] FMT_RGB  = 3'd4;
  localparam logic [2:0] FMT_RGBA = 3'd5;

  // result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_SMALL = 2'd1;
  localparam logic [1:0] STAT_UNSUP = 2'd2;
  localparam logic [1:0] STAT_LARGE = 2'd3;

  // register indexes
  localparam logic [2:0] REG_PIXEL_FORMAT    = 3'd0;
  localparam logic [2:0] REG_IMAGE_WIDTH     = 3'd1;
  localparam logic [2:0] REG_X_START         = 3'd2;
  localparam logic [2:0] REG_Y_START         = 3'd3;
  localparam logic [2:0] REG_USE_WIDTH       = 3'd4;
  localparam logic [2:0] REG_USE_HEIGHT      = 3'd5;
  localparam logic [2:0] REG_SAMPLE_FRACTION = 3'd6;

  // datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_START,
    OP_NS,
    OP_CHECK,
    OP_DIV_STRIDE,
    OP_FIX_STRIDE,
    OP_DIV_TARGET,
    OP_LOAD_TARGET,
    OP_PIX_HELD,
    OP_PIX,
    OP_FIN_INIT,
    OP_DIV_MEAN,
    OP_LOAD_MEAN,
    OP_MUL_A,
    OP_MUL_B,
    OP_STORE_B,
    OP_DIV_VAR,
    OP_SQRT,
    OP_LOAD_SD,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic mul_busy;
    logic sqrt_busy;
    logic frame_ok;
    logic n_zero;
    logic n_many;
    logic a_ge_b;
    logic at_last;
  } dp_stat_t;

  typedef struct packed {
    logic [2:0]  pixel_format;
    logic [16:0] image_width;
    logic [15:0] x_start;
    logic [15:0] y_start;
    logic [16:0] use_width;
    logic [16:0] use_height;
    logic [16:0] sample_fraction;
  } cfg_t;

  // raw pixel to signed value, rgb as luminance times 100
  function automatic logic signed [VAL_W-1:0] pixel_to_value(input logic [2:0] fmt,
                                                             input logic [31:0] p);
    logic [VAL_W-1:0] rgb;
    logic [VAL_W-1:0] v;
    rgb = WEIGHT_RED * 17'(p[7:0]) + WEIGHT_GREEN * 17'(p[15:8]) +
          WEIGHT_BLUE * 17'(p[23:16]);
    unique case (fmt)
      FMT_U8:  v = {9'd0, p[7:0]};
      FMT_S8:  v = {{9{p[7]}}, p[7:0]};
      FMT_U16: v = {1'b0, p[15:0]};
      FMT_S16: v = {p[15], p[15:0]};
      default: v = rgb;
    endcase
    return signed'(v);
  endfunction

endpackage

// ----- hdl/srms_if.sv -----
// request channels for pixels in and statistics out
interface srms_pix_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_value;
  logic        frame_start;
  modport source(output valid, pixel_value, frame_start, input ready);
  modport sink(input valid, pixel_value, frame_start, output ready);
endinterface

interface srms_res_if;
  logic               valid;
  logic               ready;
  logic signed [24:0] mean_value;
  logic [23:0]        std_dev;
  logic [1:0]         status;
  logic [24:0]        sample_count;
  modport source(output valid, mean_value, std_dev, status, sample_count, input ready);
  modport sink(input valid, mean_value, std_dev, status, sample_count, output ready);
endinterface

// ----- hdl/srms_div.sv -----
// restoring divider, one quotient bit per cycle
module srms_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [srms_pkg::DVD_W-1:0]   dividend,
  input  logic [srms_pkg::DVS_W-1:0]   divisor,
  output logic                         busy,
  output logic [srms_pkg::QUO_W-1:0]   quotient
);
  import srms_pkg::*;

  localparam int unsigned CW = $clog2(DVD_W);

  logic [DVD_W-1:0] dvd;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   rem;
  logic [CW-1:0]    cnt;
  logic [DVS_W+1:0] rem_sh;
  logic [DVS_W+1:0] diff;
  logic             ge;

  // trial subtract
  always_comb begin
    rem_sh = {rem, dvd[DVD_W-1]};
    diff   = rem_sh - {2'b00, dvs};
    ge     = rem_sh >= {2'b00, dvs};
  end

  // iteration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      dvd  <= dividend;
      dvs  <= divisor;
      rem  <= '0;
    end else if (busy) begin
      dvd      <= {dvd[DVD_W-2:0], 1'b0};
      rem      <= ge ? diff[DVS_W:0] : rem_sh[DVS_W:0];
      quotient <= {quotient[QUO_W-2:0], ge};
      cnt      <= cnt + 1'b1;
      if (cnt == CW'(DVD_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ----- hdl/srms_dp.sv -----
// datapath: region counters, sum pipeline, setup and finish arithmetic
module srms_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  srms_pkg::cfg_t        cfg,
  input  srms_pkg::cmd_t        cmd,
  input  logic [31:0]           pixel_value,
  output srms_pkg::dp_stat_t    stat,
  output logic signed [24:0]    mean_value,
  output logic [23:0]           std_dev,
  output logic [1:0]            status,
  output logic [24:0]           sample_count
);
  import srms_pkg::*;

  // frame counters
  logic [POS_W-1:0] col, row;
  logic [CNT_W-1:0] region_index, next_index, taken, stride, target;
  logic [1:0]       frame_status;
  logic [31:0]      held_pix;
  logic [NPIX_W-1:0] npix, ns;
  logic [NPIX_W:0]   ns_raw;

  // sum pipeline
  logic                    s1_hit, s2_hit;
  logic signed [VAL_W-1:0] s1_v, s2_v;
  logic [32:0]             s2_sq;
  logic signed [SUM_W-1:0] value_sum;
  logic [SQSUM_W-1:0]      square_sum;

  // finish registers
  logic [CNT_W-1:0]  n_r;
  logic [SUM_W-1:0]  mag;
  logic              neg, scale_rgb;
  logic [49:0]       nn1;
  logic [DVS_W-1:0]  dvs_var;
  logic [PROD_W-1:0] a_prod, b_prod;
  logic signed [24:0] mean_r;
  logic [23:0]       sd_r;

  // serial multiplier and root
  logic [PROD_W-1:0] mul_acc, mul_mc;
  logic [MPLR_W-1:0] mul_mp;
  logic [5:0]        mul_cnt;
  logic              mul_busy;
  logic [SQRT_W-1:0] sq_x, sq_res, sq_bit, sq_t;
  logic              sqrt_busy;

  // divider hookup
  logic              div_start, div_busy;
  logic [DVD_W-1:0]  div_dvd;
  logic [DVS_W-1:0]  div_dvs;
  logic [QUO_W-1:0]  div_q;

  // pixel step decode
  logic [17:0]       xe, ye;
  logic              in_reg, hit, at_last, wrap, pix_op;
  logic [16:0]       w_eff;
  logic [31:0]       pix;
  logic [CNT_W-1:0]  s_q;
  logic [NPIX_W+16:0] ns_prod;
  logic [31:0]       mean_dvs;
  logic [63:0]       dvs_full;
  logic signed [33:0] sq_full;
  logic [1:0]        status_next;
  logic [NPIX_W-1:0] ns_clamp;

  always_comb begin
    pix_op  = (cmd.op == OP_PIX) || (cmd.op == OP_PIX_HELD);
    pix     = (cmd.op == OP_PIX_HELD) ? held_pix : pixel_value;
    xe      = 18'(cfg.x_start) + 18'(cfg.use_width);
    ye      = 18'(cfg.y_start) + 18'(cfg.use_height);
    in_reg  = (col >= cfg.x_start) && (18'(col) < xe) &&
              (row >= cfg.y_start) && (18'(row) < ye);
    at_last = in_reg && (18'(col) + 18'd1 == xe) && (18'(row) + 18'd1 == ye);
    hit     = in_reg && (region_index == next_index) && (taken < target);
    if (cfg.image_width == '0) begin
      w_eff = 17'd1;
    end else if (cfg.image_width > 17'(MAX_IMAGE_WIDTH)) begin
      w_eff = 17'(MAX_IMAGE_WIDTH);
    end else begin
      w_eff = cfg.image_width;
    end
    wrap = (17'(col) + 17'd1) >= w_eff;
  end

  // setup and finish arithmetic
  always_comb begin
    ns_prod  = 51'(cfg.sample_fraction) * 51'(npix);
    ns_clamp = (ns_raw > 35'(npix)) ? npix : ns_raw[NPIX_W-1:0];
    s_q      = div_q[CNT_W-1:0];
    if (cfg.use_width < 17'd2 || cfg.use_height < 17'd2 || ns_clamp < MIN_SAMPLES) begin
      status_next = STAT_SMALL;
    end else if (cfg.pixel_format > FMT_RGBA) begin
      status_next = STAT_UNSUP;
    end else if (npix > NPIX_W'(MAX_REGION_PIXELS)) begin
      status_next = STAT_LARGE;
    end else begin
      status_next = STAT_OK;
    end
    mean_dvs = 32'(n_r) * 32'(scale_rgb ? RGB_SCALE : 7'd1);
    dvs_full = 64'(nn1) * 64'(scale_rgb ? RGB_SCALE_SQ : 14'd1);
    sq_full  = 34'(s1_v) * 34'(s1_v);
    sq_t     = sq_res + sq_bit;
  end

  // divider operand select
  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    unique case (cmd.op)
      OP_DIV_STRIDE: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'(npix);
        div_dvs   = DVS_W'(ns);
      end
      OP_DIV_TARGET: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'(npix);
        div_dvs   = DVS_W'(stride);
      end
      OP_DIV_MEAN: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'({mag, 8'd0});
        div_dvs   = DVS_W'(mean_dvs);
      end
      OP_DIV_VAR: begin
        div_start = 1'b1;
        div_dvd   = {a_prod - b_prod, 16'd0};
        div_dvs   = dvs_var;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  srms_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // frame counters and setup results
  always_ff @(posedge clk) begin
    if (rst) begin
      col          <= '0;
      row          <= '0;
      region_index <= '0;
      next_index   <= '0;
      taken        <= '0;
      stride       <= 25'd1;
      target       <= '0;
      frame_status <= STAT_SMALL;
    end else begin
      unique case (cmd.op)
        OP_START: begin
          held_pix     <= pixel_value;
          col          <= '0;
          row          <= '0;
          region_index <= '0;
          next_index   <= '0;
          taken        <= '0;
          stride       <= 25'd1;
          target       <= '0;
          npix         <= NPIX_W'(cfg.use_width) * NPIX_W'(cfg.use_height);
        end
        OP_NS: begin
          ns_raw <= ns_prod[NPIX_W+16:16];
        end
        OP_CHECK: begin
          ns           <= ns_clamp;
          frame_status <= status_next;
        end
        OP_FIX_STRIDE: begin
          stride <= (s_q > STRIDE_ADJUST_ABOVE && s_q[0] == npix[0]) ? s_q - 25'd1 : s_q;
        end
        OP_LOAD_TARGET: begin
          target <= s_q;
        end
        OP_PIX, OP_PIX_HELD: begin
          if (in_reg) begin
            region_index <= region_index + 25'd1;
          end
          if (hit) begin
            taken      <= taken + 25'd1;
            next_index <= next_index + stride;
          end
          if (wrap) begin
            col <= '0;
            row <= row + 16'd1;
          end else begin
            col <= col + 16'd1;
          end
        end
        default: begin
          held_pix <= held_pix;
        end
      endcase
    end
  end

  // sum pipeline: value, square, accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_hit     <= 1'b0;
      s2_hit     <= 1'b0;
      value_sum  <= '0;
      square_sum <= '0;
    end else begin
      s1_hit <= pix_op && hit;
      s1_v   <= pixel_to_value(cfg.pixel_format, pix);
      s2_hit <= s1_hit;
      s2_v   <= s1_v;
      s2_sq  <= sq_full[32:0];
      if (cmd.op == OP_CHECK) begin
        value_sum  <= '0;
        square_sum <= '0;
      end else if (s2_hit) begin
        value_sum  <= value_sum + SUM_W'(s2_v);
        square_sum <= square_sum + SQSUM_W'(s2_sq);
      end
    end
  end

  // serial shift-add multiplier, magnitude of the sum stays below 2^40
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_busy <= 1'b0;
      mul_cnt  <= '0;
    end else if (cmd.op == OP_MUL_A || cmd.op == OP_MUL_B) begin
      mul_busy <= 1'b1;
      mul_cnt  <= '0;
      mul_acc  <= '0;
      mul_mc   <= (cmd.op == OP_MUL_A) ? PROD_W'(square_sum) : PROD_W'(mag);
      mul_mp   <= (cmd.op == OP_MUL_A) ? MPLR_W'(n_r) : MPLR_W'(mag);
    end else if (mul_busy) begin
      if (mul_mp[0]) begin
        mul_acc <= mul_acc + mul_mc;
      end
      mul_mc  <= {mul_mc[PROD_W-2:0], 1'b0};
      mul_mp  <= {1'b0, mul_mp[MPLR_W-1:1]};
      mul_cnt <= mul_cnt + 6'd1;
      if (mul_cnt == 6'(MPLR_W - 1)) begin
        mul_busy <= 1'b0;
      end
    end
  end

  // digit-by-digit square root, two bits per step
  always_ff @(posedge clk) begin
    if (rst) begin
      sqrt_busy <= 1'b0;
    end else if (cmd.op == OP_SQRT) begin
      sqrt_busy <= 1'b1;
      sq_x      <= div_q;
      sq_res    <= '0;
      sq_bit    <= SQRT_W'(1) << (SQRT_W - 2);
    end else if (sqrt_busy) begin
      if (sq_x >= sq_t) begin
        sq_x   <= sq_x - sq_t;
        sq_res <= (sq_res >> 1) + sq_bit;
      end else begin
        sq_res <= sq_res >> 1;
      end
      sq_bit <= sq_bit >> 2;
      if (sq_bit == SQRT_W'(1)) begin
        sqrt_busy <= 1'b0;
      end
    end
  end

  // finish sequence and result registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_FIN_INIT: begin
        n_r       <= taken;
        mag       <= value_sum[SUM_W-1] ? SUM_W'(-value_sum) : SUM_W'(value_sum);
        neg       <= value_sum[SUM_W-1];
        scale_rgb <= cfg.pixel_format >= FMT_RGB;
        nn1       <= 50'(taken) * 50'(taken - 25'd1);
        mean_r    <= '0;
        sd_r      <= '0;
      end
      OP_LOAD_MEAN: begin
        mean_r <= neg ? signed'(-div_q[24:0]) : signed'(div_q[24:0]);
      end
      OP_MUL_A: begin
        dvs_var <= dvs_full[DVS_W-1:0];
      end
      OP_MUL_B: begin
        a_prod <= mul_acc;
      end
      OP_STORE_B: begin
        b_prod <= mul_acc;
      end
      OP_LOAD_SD: begin
        sd_r <= sq_res[23:0];
      end
      OP_EMIT: begin
        mean_value   <= mean_r;
        std_dev      <= sd_r;
        status       <= frame_status;
        sample_count <= (frame_status == STAT_OK) ? n_r : '0;
      end
      default: begin
        sd_r <= sd_r;
      end
    endcase
  end

  // status to the controller
  always_comb begin
    stat.div_busy  = div_busy;
    stat.mul_busy  = mul_busy;
    stat.sqrt_busy = sqrt_busy;
    stat.frame_ok  = frame_status == STAT_OK;
    stat.n_zero    = n_r == '0;
    stat.n_many    = n_r > 25'd1;
    stat.a_ge_b    = a_prod >= b_prod;
    stat.at_last   = at_last;
  end

endmodule

// ----- hdl/srms_ctrl.sv -----
// controller: frame setup, pixel acceptance and finish sequencing
module srms_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_frame_start,
  output logic               in_ready,
  input  logic               out_ready,
  output logic               out_valid,
  input  srms_pkg::dp_stat_t stat,
  output srms_pkg::cmd_t     cmd
);
  import srms_pkg::*;

  typedef enum logic [4:0] {
    ST_DONE, ST_NS, ST_CHECK, ST_BRANCH, ST_WAIT_S, ST_TGT_GO, ST_WAIT_T, ST_PROC,
    ST_RUN, ST_DRAIN1, ST_DRAIN2, ST_FIN, ST_FIN_BR, ST_WAIT_M, ST_MUL_A,
    ST_WAIT_A, ST_WAIT_B, ST_CMP, ST_WAIT_V, ST_WAIT_R, ST_OUT
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_ready = (state == ST_DONE) || (state == ST_RUN);
  assign accept   = in_valid && in_ready;

  // next state and operation
  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    unique case (state)
      ST_DONE: begin
        if (accept && in_frame_start) begin
          cmd.op     = OP_START;
          state_next = ST_NS;
        end
      end
      ST_RUN: begin
        if (accept) begin
          if (in_frame_start) begin
            cmd.op     = OP_START;
            state_next = ST_NS;
          end else begin
            cmd.op = OP_PIX;
            if (stat.at_last) begin
              state_next = ST_DRAIN1;
            end
          end
        end
      end
      ST_NS: begin
        cmd.op     = OP_NS;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.op     = OP_CHECK;
        state_next = ST_BRANCH;
      end
      ST_BRANCH: begin
        if (stat.frame_ok) begin
          cmd.op     = OP_DIV_STRIDE;
          state_next = ST_WAIT_S;
        end else begin
          state_next = ST_PROC;
        end
      end
      ST_WAIT_S: begin
        if (!stat.div_busy) begin
          cmd.op     = OP_FIX_STRIDE;
          state_next = ST_TGT_GO;
        end
      end
      ST_TGT_GO: begin
        cmd.op     = OP_DIV_TARGET;
        state_next = ST_WAIT_T;
      end
      ST_WAIT_T: begin
        if (!stat.div_busy) begin
          cmd.op     = OP_LOAD_TARGET;
          state_next = ST_PROC;
        end
      end
      ST_PROC: begin
        cmd.op     = OP_PIX_HELD;
        state_next = stat.at_last ? ST_DRAIN1 : ST_RUN;
      end
      ST_DRAIN1: state_next = ST_DRAIN2;
      ST_DRAIN2: state_next = ST_FIN;
      ST_FIN: begin
        cmd.op     = OP_FIN_INIT;
        state_next = ST_FIN_BR;
      end
      ST_FIN_BR: begin
        if (!stat.frame_ok || stat.n_zero) begin
          state_next = ST_OUT;
        end else begin
          cmd.op     = OP_DIV_MEAN;
          state_next = ST_WAIT_M;
        end
      end
      ST_WAIT_M: begin
        if (!stat.div_busy) begin
          cmd.op     = OP_LOAD_MEAN;
          state_next = stat.n_many ? ST_MUL_A : ST_OUT;
        end
      end
      ST_MUL_A: begin
        cmd.op     = OP_MUL_A;
        state_next = ST_WAIT_A;
      end
      ST_WAIT_A: begin
        if (!stat.mul_busy) begin
          cmd.op     = OP_MUL_B;
          state_next = ST_WAIT_B;
        end
      end
      ST_WAIT_B: begin
        if (!stat.mul_busy) begin
          cmd.op     = OP_STORE_B;
          state_next = ST_CMP;
        end
      end
      ST_CMP: begin
        if (stat.a_ge_b) begin
          cmd.op     = OP_DIV_VAR;
          state_next = ST_WAIT_V;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_WAIT_V: begin
        if (!stat.div_busy) begin
          cmd.op     = OP_SQRT;
          state_next = ST_WAIT_R;
        end
      end
      ST_WAIT_R: begin
        if (!stat.sqrt_busy) begin
          cmd.op     = OP_LOAD_SD;
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.op     = OP_EMIT;
          state_next = ST_DONE;
        end
      end
      default: state_next = ST_DONE;
    endcase
  end

  // state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_DONE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.op == OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- hdl/sampled_region_mean_sd_top.sv -----
// top level: register port, controller and datapath of the region mean and sd block
//
//  channel  dir  request carries
//  pixel    in   pixel_value, frame_start
//  result   out  mean_value, std_dev, status, sample_count
//  apb      in   register writes and reads, no wait states
//
// Inside a frame one pixel is taken per cycle. A frame_start request stalls
// the input during setup, which for a valid configuration runs the serial divider twice.
// The last region pixel starts the finish sequence, which at most runs the divider
// twice, the shift-add multiplier twice and a 32-step square root.
// Pixels are taken again while a result waits; a new result waits for the old one.
// Synchronous reset; no pixel is counted before the first frame_start.
module sampled_region_mean_sd_top (
  input  logic        clk,
  input  logic        rst,
  srms_pix_if.sink    pixel,
  srms_res_if.source  result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import srms_pkg::*;

  cfg_t     cfg;
  cmd_t     cmd;
  dp_stat_t dp_stat;
  logic     wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pixel_format    <= FMT_U8;
      cfg.image_width     <= 17'd1;
      cfg.x_start         <= '0;
      cfg.y_start         <= '0;
      cfg.use_width       <= 17'd1;
      cfg.use_height      <= 17'd1;
      cfg.sample_fraction <= 17'd65536;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PIXEL_FORMAT:    cfg.pixel_format    <= pwdata[2:0];
        REG_IMAGE_WIDTH:     cfg.image_width     <= pwdata[16:0];
        REG_X_START:         cfg.x_start         <= pwdata[15:0];
        REG_Y_START:         cfg.y_start         <= pwdata[15:0];
        REG_USE_WIDTH:       cfg.use_width       <= pwdata[16:0];
        REG_USE_HEIGHT:      cfg.use_height      <= pwdata[16:0];
        REG_SAMPLE_FRACTION: cfg.sample_fraction <= pwdata[16:0];
        default:             cfg.x_start         <= cfg.x_start;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (reg_idx)
      REG_PIXEL_FORMAT:    prdata = 32'(cfg.pixel_format);
      REG_IMAGE_WIDTH:     prdata = 32'(cfg.image_width);
      REG_X_START:         prdata = 32'(cfg.x_start);
      REG_Y_START:         prdata = 32'(cfg.y_start);
      REG_USE_WIDTH:       prdata = 32'(cfg.use_width);
      REG_USE_HEIGHT:      prdata = 32'(cfg.use_height);
      REG_SAMPLE_FRACTION: prdata = 32'(cfg.sample_fraction);
      default:             prdata = '0;
    endcase
  end

  srms_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (pixel.valid),
    .in_frame_start (pixel.frame_start),
    .in_ready       (pixel.ready),
    .out_ready      (result.ready),
    .out_valid      (result.valid),
    .stat           (dp_stat),
    .cmd            (cmd)
  );

  srms_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .pixel_value  (pixel.pixel_value),
    .stat         (dp_stat),
    .mean_value   (result.mean_value),
    .std_dev      (result.std_dev),
    .status       (result.status),
    .sample_count (result.sample_count)
  );

  // no pixel taken while the divider works
  assert property (@(posedge clk) disable iff (rst) dp_stat.div_busy |-> !pixel.ready)
    else $error("pixel taken during division");

  // a result appears only after the emit step
  assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(cmd.op == OP_EMIT))
    else $error("result without emit");

  // error results carry no statistics
  assert property (@(posedge clk) disable iff (rst)
    result.valid && result.status != STAT_OK |->
      result.sample_count == '0 && result.mean_value == '0 && result.std_dev == '0)
    else $error("error result with statistics");

  // a spread needs at least two samples
  assert property (@(posedge clk) disable iff (rst)
    result.valid && result.std_dev != '0 |-> result.sample_count > 25'd1)
    else $error("nonzero sd from fewer than two samples");

endmodule
